### hdl/four_level_page_table_walker_unit_macros.svh
// Assertion macros shared by the page table walker RTL
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked at every rising edge outside reset
`define PTW_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define PTW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PTW_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define PTW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hdl/ptw_pkg.sv
// Shared constants, types and control word layout for the page table walker
`timescale 1ns / 1ps
`default_nettype none
package ptw_pkg;

	// store geometry
	localparam int TABLE_FRAMES      = 8;
	localparam int ENTRIES_PER_TABLE = 512;
	localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
	localparam int FRAME_W           = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
	localparam int ADDR_W            = FRAME_W + IDX_W;
	localparam int STORE_DEPTH       = TABLE_FRAMES * ENTRIES_PER_TABLE;
	// allocation count and per-frame clear epoch (a frame is cleared at most once per alloc)
	localparam int CNT_W             = $clog2(TABLE_FRAMES + 1);
	localparam int EPOCH_W           = CNT_W;

	// field widths
	localparam int VA_W       = 48;
	localparam int PA_W       = 52;
	localparam int ENTRY_W    = 52;
	localparam int OFFSET_W   = 12;
	localparam int STATUS_W   = 2;
	localparam int ROOT_W     = 3;
	localparam int FIRST_W    = 4;
	localparam int FLAGS_W    = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam int LEVEL_W    = 2;

	// virtual address index positions, top level first
	localparam int SHIFT_L0 = 39;
	localparam int SHIFT_L1 = 30;
	localparam int SHIFT_L2 = 21;
	localparam int SHIFT_L3 = 12;

	// last upper level before the leaf table
	localparam logic [LEVEL_W-1:0] LAST_UPPER = LEVEL_W'(2);

	// request mode
	localparam logic MODE_TRANSLATE = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROOT  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_FLAGS = CFG_IDX_W'(2);

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_NOT_MAPPED = 2'd1,
		ST_NO_FRAMES  = 2'd2,
		ST_OUTSIDE    = 2'd3
	} status_t;

	// microcode step addresses
	localparam int STEP_W = 5;
	typedef logic [STEP_W-1:0] step_t;
	localparam step_t S_IDLE      = step_t'(0);
	localparam step_t S_ROOT      = step_t'(1);
	localparam step_t S_READ      = step_t'(2);
	localparam step_t S_TEST      = step_t'(3);
	localparam step_t S_DESCEND   = step_t'(4);
	localparam step_t S_NEXT      = step_t'(5);
	localparam step_t S_LEAF      = step_t'(6);
	localparam step_t S_MAP_LEAF  = step_t'(7);
	localparam step_t S_LEAF_RD   = step_t'(8);
	localparam step_t S_LEAF_OUT  = step_t'(9);
	localparam step_t S_ZERO      = step_t'(10);
	localparam step_t S_ALLOC_CHK = step_t'(11);
	localparam step_t S_ALLOC     = step_t'(12);
	localparam step_t S_LINK      = step_t'(13);
	localparam step_t S_FIN_OUT   = step_t'(14);
	localparam step_t S_FIN_NOMAP = step_t'(15);
	localparam step_t S_FIN_NOFR  = step_t'(16);

	// jump conditions
	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_INPUT,
		C_ROOT_BAD,
		C_ZERO,
		C_ENTRY_BAD,
		C_MORE_LEVELS,
		C_TRANSLATE,
		C_NO_FRAME
	} cond_sel_t;

	typedef enum logic [1:0] {
		MEM_NONE,
		MEM_READ,
		MEM_WR_LINK,
		MEM_WR_LEAF
	} mem_op_t;

	typedef enum logic [1:0] {
		TBL_HOLD,
		TBL_ROOT,
		TBL_ENTRY,
		TBL_ALLOC
	} tbl_op_t;

	// one microinstruction
	typedef struct packed {
		cond_sel_t cond;
		step_t     target;
		mem_op_t   mem_op;
		tbl_op_t   tbl_op;
		logic      lvl_inc;
		logic      alloc;
		logic      fin;
		status_t   fin_status;
		logic      tlb;
	} ctl_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic clearing;
		logic out_full;
		logic root_bad;
		logic zero;
		logic entry_bad;
		logic more_levels;
		logic translate;
		logic no_frame;
	} cond_flags_t;

	// single-port store access
	typedef struct packed {
		logic               re;
		logic               we;
		logic [ADDR_W-1:0]  addr;
		logic [ENTRY_W-1:0] wdata;
		logic [EPOCH_W-1:0] wtag;
	} store_req_t;

endpackage
`default_nettype wire

### hdl/ptw_store.sv
// Table store: single-port entry memory with epoch tags and post-reset clearing pass
`timescale 1ns / 1ps
`default_nettype none
`include "four_level_page_table_walker_unit_macros.svh"
module ptw_store (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ptw_pkg::store_req_t          req,
	output logic [ptw_pkg::ENTRY_W-1:0]  rd_data,
	output logic [ptw_pkg::EPOCH_W-1:0]  rd_tag,
	output logic                         busy
);
	import ptw_pkg::*;

	typedef struct packed {
		logic [EPOCH_W-1:0] tag;
		logic [ENTRY_W-1:0] data;
	} word_t;

	word_t              mem [STORE_DEPTH];
	word_t              rd_q;
	word_t              wd;
	logic               we;
	logic [ADDR_W-1:0]  wa;
	logic               clr_q;
	logic [ADDR_W-1:0]  clr_addr_q;

	// clearing pass: one entry per cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == ADDR_W'(STORE_DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
		end
	end

	// write port shared between the clearing pass and the walker
	always_comb begin
		if (clr_q) begin
			we = 1'b1;
			wa = clr_addr_q;
			wd = '0;
		end else begin
			we = req.we;
			wa = req.addr;
			wd = '{tag: req.wtag, data: req.wdata};
		end
	end

	// memory array, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (req.re) begin
			rd_q <= mem[req.addr];
		end
	end

	assign rd_data = rd_q.data;
	assign rd_tag  = rd_q.tag;
	assign busy    = clr_q;

	`PTW_ASSERT_IMPLIES(a_no_access_while_clearing, clr_q, !(req.re || req.we), "store accessed during clearing pass")

endmodule
`default_nettype wire

### hdl/ptw_datapath.sv
// Walker datapath: config registers, walk registers, allocator, epochs, result register
`timescale 1ns / 1ps
`default_nettype none
`include "four_level_page_table_walker_unit_macros.svh"
module ptw_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ptw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ptw_pkg::CFG_DATA_W-1:0]  cfg_data,
	// request payload
	input  logic                            in_take,
	input  logic                            mode,
	input  logic [ptw_pkg::VA_W-1:0]        virtual_address,
	input  logic [ptw_pkg::PA_W-1:0]        physical_address,
	// sequencer link
	input  ptw_pkg::ctl_t                   ctl,
	output ptw_pkg::cond_flags_t            flags,
	// store link
	output ptw_pkg::store_req_t             store_req,
	input  logic [ptw_pkg::ENTRY_W-1:0]     rd_data,
	input  logic [ptw_pkg::EPOCH_W-1:0]     rd_tag,
	input  logic                            store_busy,
	// result
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [ptw_pkg::STATUS_W-1:0]    status,
	output logic [ptw_pkg::PA_W-1:0]        translated_address,
	output logic                            tlb_invalidate
);
	import ptw_pkg::*;

	logic [ROOT_W-1:0]        root_q;
	logic [FIRST_W-1:0]       first_q;
	logic [FLAGS_W-1:0]       flags_q;
	logic                     mode_q;
	logic [VA_W-1:0]          va_q;
	logic [PA_W-1:0]          pa_q;
	logic [FRAME_W-1:0]       table_q;
	logic [FRAME_W-1:0]       alloc_q;
	logic [LEVEL_W-1:0]       lvl_q;
	logic [CNT_W-1:0]         count_q;
	logic [EPOCH_W-1:0]       epoch_q [TABLE_FRAMES];
	logic                     out_valid_q;
	status_t                  status_q;
	logic [PA_W-1:0]          trans_q;
	logic                     tlb_q;

	logic [IDX_W-1:0]         idx;
	logic [ENTRY_W-1:0]       entry;
	logic [ENTRY_W-OFFSET_W-1:0] entry_frame;
	logic [31:0]              nf_sum;
	logic [FRAME_W-1:0]       nf_frame;
	logic                     translate;

	assign cfg_ready = 1'b1;

	// configuration writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q  <= '0;
			first_q <= FIRST_W'(1);
			flags_q <= FLAGS_W'(3);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ROOT:  root_q  <= cfg_data[ROOT_W-1:0];
				CFG_FIRST: first_q <= cfg_data[FIRST_W-1:0];
				CFG_FLAGS: flags_q <= cfg_data[FLAGS_W-1:0];
				default: ;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (in_take) begin
			mode_q <= mode;
			va_q   <= virtual_address;
			pa_q   <= physical_address;
		end
	end

	assign translate = (mode_q == MODE_TRANSLATE);

	// table index for the current level
	always_comb begin
		case (lvl_q)
			2'd0:    idx = va_q[SHIFT_L0 +: IDX_W];
			2'd1:    idx = va_q[SHIFT_L1 +: IDX_W];
			2'd2:    idx = va_q[SHIFT_L2 +: IDX_W];
			default: idx = va_q[SHIFT_L3 +: IDX_W];
		endcase
	end

	// an entry written before its frame's last clear reads as zero
	assign entry       = (rd_tag == epoch_q[table_q]) ? rd_data : '0;
	assign entry_frame = entry[ENTRY_W-1:OFFSET_W];

	// bump allocator candidate
	assign nf_sum   = 32'(first_q) + 32'(count_q);
	assign nf_frame = nf_sum[FRAME_W-1:0];

	// branch conditions
	always_comb begin
		flags.clearing    = store_busy;
		flags.out_full    = out_valid_q && out_stall;
		flags.root_bad    = !(32'(root_q) < 32'(TABLE_FRAMES));
		flags.zero        = (entry == '0);
		flags.entry_bad   = !(64'(entry_frame) < 64'(TABLE_FRAMES));
		flags.more_levels = (lvl_q != LAST_UPPER);
		flags.translate   = translate;
		flags.no_frame    = !(nf_sum < 32'(TABLE_FRAMES));
	end

	// store access
	always_comb begin
		store_req.re    = (ctl.mem_op == MEM_READ);
		store_req.we    = (ctl.mem_op == MEM_WR_LINK) || (ctl.mem_op == MEM_WR_LEAF);
		store_req.addr  = {table_q, idx};
		store_req.wtag  = epoch_q[table_q];
		if (ctl.mem_op == MEM_WR_LINK) begin
			store_req.wdata = ENTRY_W'({alloc_q, {OFFSET_W{1'b0}}}) | ENTRY_W'(flags_q);
		end else begin
			store_req.wdata = pa_q | ENTRY_W'(flags_q);
		end
	end

	// walk position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_q <= '0;
			lvl_q   <= '0;
		end else begin
			case (ctl.tbl_op)
				TBL_ROOT: begin
					table_q <= FRAME_W'(root_q);
					lvl_q   <= '0;
				end
				TBL_ENTRY: table_q <= FRAME_W'(entry_frame);
				TBL_ALLOC: table_q <= alloc_q;
				default: ;
			endcase
			if (ctl.lvl_inc) begin
				lvl_q <= lvl_q + LEVEL_W'(1);
			end
		end
	end

	// allocator: clearing a frame is a bump of its epoch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			alloc_q <= '0;
			epoch_q <= '{default: '0};
		end else if (ctl.alloc) begin
			count_q           <= count_q + CNT_W'(1);
			alloc_q           <= nf_frame;
			epoch_q[nf_frame] <= epoch_q[nf_frame] + EPOCH_W'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.fin) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fin) begin
			status_q <= ctl.fin_status;
			tlb_q    <= ctl.tlb;
			if ((ctl.fin_status == ST_OK) && translate) begin
				trans_q <= {entry_frame, va_q[OFFSET_W-1:0]};
			end else begin
				trans_q <= '0;
			end
		end
	end

	assign out_valid          = out_valid_q;
	assign status             = status_q;
	assign translated_address = trans_q;
	assign tlb_invalidate     = tlb_q;

	`PTW_ASSERT_IMPLIES(a_alloc_in_range, ctl.alloc, !flags.no_frame, "allocation past last frame")
	`PTW_ASSERT_IMPLIES(a_count_bound, 1'b1, 32'(count_q) <= 32'(TABLE_FRAMES), "allocation count overflow")

endmodule
`default_nettype wire

### hdl/ptw_sequencer.sv
// Microcode sequencer: step counter, control ROM and conditional jumps
`timescale 1ns / 1ps
`default_nettype none
`include "four_level_page_table_walker_unit_macros.svh"
module ptw_sequencer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  in_take,
	input  ptw_pkg::cond_flags_t  flags,
	output ptw_pkg::ctl_t         ctl
);
	import ptw_pkg::*;

	localparam ctl_t CTL_NOP = '{
		cond: C_NEVER, target: S_IDLE, mem_op: MEM_NONE, tbl_op: TBL_HOLD,
		lvl_inc: 1'b0, alloc: 1'b0, fin: 1'b0, fin_status: ST_OK, tlb: 1'b0
	};

	// control ROM
	function automatic ctl_t ucode(input step_t s);
		ctl_t w;
		w = CTL_NOP;
		case (s)
			S_IDLE: begin
				w.cond = C_NO_INPUT; w.target = S_IDLE;
			end
			S_ROOT: begin
				w.cond = C_ROOT_BAD; w.target = S_FIN_OUT; w.tbl_op = TBL_ROOT;
			end
			S_READ: begin
				w.mem_op = MEM_READ;
			end
			S_TEST: begin
				w.cond = C_ZERO; w.target = S_ZERO;
			end
			S_DESCEND: begin
				w.cond = C_ENTRY_BAD; w.target = S_FIN_OUT; w.tbl_op = TBL_ENTRY;
			end
			S_NEXT: begin
				w.cond = C_MORE_LEVELS; w.target = S_READ; w.lvl_inc = 1'b1;
			end
			S_LEAF: begin
				w.cond = C_TRANSLATE; w.target = S_LEAF_RD;
			end
			S_MAP_LEAF: begin
				w.cond = C_ALWAYS; w.target = S_IDLE; w.mem_op = MEM_WR_LEAF;
				w.fin = 1'b1; w.fin_status = ST_OK; w.tlb = 1'b1;
			end
			S_LEAF_RD: begin
				w.mem_op = MEM_READ;
			end
			S_LEAF_OUT: begin
				w.cond = C_ALWAYS; w.target = S_IDLE; w.fin = 1'b1; w.fin_status = ST_OK;
			end
			S_ZERO: begin
				w.cond = C_TRANSLATE; w.target = S_FIN_NOMAP;
			end
			S_ALLOC_CHK: begin
				w.cond = C_NO_FRAME; w.target = S_FIN_NOFR;
			end
			S_ALLOC: begin
				w.alloc = 1'b1;
			end
			S_LINK: begin
				w.cond = C_ALWAYS; w.target = S_NEXT;
				w.mem_op = MEM_WR_LINK; w.tbl_op = TBL_ALLOC;
			end
			S_FIN_OUT: begin
				w.cond = C_ALWAYS; w.target = S_IDLE; w.fin = 1'b1; w.fin_status = ST_OUTSIDE;
			end
			S_FIN_NOMAP: begin
				w.cond = C_ALWAYS; w.target = S_IDLE; w.fin = 1'b1;
				w.fin_status = ST_NOT_MAPPED;
			end
			S_FIN_NOFR: begin
				w.cond = C_ALWAYS; w.target = S_IDLE; w.fin = 1'b1;
				w.fin_status = ST_NO_FRAMES;
			end
			default: begin
				w.cond = C_ALWAYS; w.target = S_IDLE;
			end
		endcase
		return w;
	endfunction

	step_t step_q;
	step_t step_d;
	ctl_t  word;
	logic  hit;
	logic  hold;

	assign word     = ucode(step_q);
	assign in_take  = (step_q == S_IDLE) && in_valid && !flags.clearing;
	assign in_stall = (step_q != S_IDLE) || flags.clearing;

	// jump condition select
	always_comb begin
		case (word.cond)
			C_NEVER:       hit = 1'b0;
			C_ALWAYS:      hit = 1'b1;
			C_NO_INPUT:    hit = !in_take;
			C_ROOT_BAD:    hit = flags.root_bad;
			C_ZERO:        hit = flags.zero;
			C_ENTRY_BAD:   hit = flags.entry_bad;
			C_MORE_LEVELS: hit = flags.more_levels;
			C_TRANSLATE:   hit = flags.translate;
			C_NO_FRAME:    hit = flags.no_frame;
			default:       hit = 1'b0;
		endcase
	end

	// a finishing step waits while the result register is still held
	assign hold = word.fin && flags.out_full;
	assign ctl  = hold ? CTL_NOP : word;

	always_comb begin
		if (hold) begin
			step_d = step_q;
		end else if (hit) begin
			step_d = word.target;
		end else begin
			step_d = step_q + step_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	`PTW_ASSERT_NEXT(a_take_starts_walk, in_take, step_q == S_ROOT, "accepted request did not start walk")
	`PTW_ASSERT_IMPLIES(a_fin_has_room, ctl.fin, !flags.out_full, "result overwrote held result")

endmodule
`default_nettype wire

### hdl/four_level_page_table_walker_unit.sv
// Top level of the four-level page table walker
// Four-level page table walker with its own table store of 8 frames x 512 entries. A request
// (mode 0 map, 1 translate) enters on in_valid/in_stall and gives exactly one result on
// out_valid/out_stall; results wait in an output register, so the downstream side may stall
// freely. Only one request is walked at a time: a microcoded sequencer runs one control word
// per cycle, but holds a finishing word while the result register is still held, over a
// single-port store with a registered read. A walk reads each upper-level table in turn,
// allocating and linking a new table for a map where an entry is zero, then writes the leaf
// entry for a map or reads it for a translate. After reset the store runs a clearing pass
// over all 4096 entries, one entry per cycle, during which in_stall is high; configuration
// writes (cfg_index 0 root frame, 1 first free frame, 2 entry flags) are taken at any time
// but belong between requests.
`timescale 1ns / 1ps
`default_nettype none
module four_level_page_table_walker_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ptw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ptw_pkg::CFG_DATA_W-1:0]  cfg_data,
	// requests
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            mode,
	input  logic [ptw_pkg::VA_W-1:0]        virtual_address,
	input  logic [ptw_pkg::PA_W-1:0]        physical_address,
	// results
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [ptw_pkg::STATUS_W-1:0]    status,
	output logic [ptw_pkg::PA_W-1:0]        translated_address,
	output logic                            tlb_invalidate
);
	import ptw_pkg::*;

	ctl_t                ctl;
	cond_flags_t         flags;
	store_req_t          store_req;
	logic                in_take;
	logic [ENTRY_W-1:0]  rd_data;
	logic [EPOCH_W-1:0]  rd_tag;
	logic                store_busy;

	// control sequencer
	ptw_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_take  (in_take),
		.flags    (flags),
		.ctl      (ctl)
	);

	// walk datapath
	ptw_datapath u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_take            (in_take),
		.mode               (mode),
		.virtual_address    (virtual_address),
		.physical_address   (physical_address),
		.ctl                (ctl),
		.flags              (flags),
		.store_req          (store_req),
		.rd_data            (rd_data),
		.rd_tag             (rd_tag),
		.store_busy         (store_busy),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.status             (status),
		.translated_address (translated_address),
		.tlb_invalidate     (tlb_invalidate)
	);

	// table store
	ptw_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (store_req),
		.rd_data (rd_data),
		.rd_tag  (rd_tag),
		.busy    (store_busy)
	);

endmodule
`default_nettype wire
